// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the grid map pose tracker.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define GMPT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define GMPT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/gmpt_pkg.sv =====
// Package for the grid map pose tracker: grid geometry, command codes,
// shared types and the coordinate and reset-value helpers. No dependencies.
`timescale 1ns / 1ps

package gmpt_pkg;

   localparam int GRID_SIZE  = 16;
   localparam int COORD_W    = $clog2(GRID_SIZE);
   localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int CENTRE     = GRID_SIZE / 2;

   localparam int CMD_W      = 3;
   localparam int IN_COORD_W = 4;
   localparam int DIR_W      = 2;
   localparam int VALUE_W    = 8;
   localparam int WALL_W     = 4;
   localparam int ENTRY_W    = VALUE_W + WALL_W;

   // Number of conditional subtractions that bring an input coordinate into the grid.
   localparam int WRAP_STEPS = (2 ** IN_COORD_W) / GRID_SIZE;

   localparam logic [CMD_W-1:0] CMD_LEFT     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_RIGHT    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FORWARD  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_WALL_REL = 3'd3;
   localparam logic [CMD_W-1:0] CMD_WALL_ABS = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SET      = 3'd5;
   localparam logic [CMD_W-1:0] CMD_READ     = 3'd6;

   localparam logic [DIR_W-1:0] HEAD_N = 2'd0;
   localparam logic [DIR_W-1:0] HEAD_E = 2'd1;
   localparam logic [DIR_W-1:0] HEAD_S = 2'd2;
   localparam logic [DIR_W-1:0] HEAD_W = 2'd3;

   localparam logic [DIR_W-1:0] REL_LEFT  = 2'd1;
   localparam logic [DIR_W-1:0] REL_RIGHT = 2'd2;

   localparam logic [WALL_W-1:0] ORIGIN_WALLS = 4'b1100;
   localparam logic [VALUE_W-1:0] CENTRE_VALUE = 8'hff;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [ENTRY_W-1:0] entry_type;

   typedef struct packed {
      coord_type        x;
      coord_type        y;
      logic [DIR_W-1:0] heading;
   } pose_type;

   typedef struct packed {
      addr_type         addr;
      logic [DIR_W-1:0] card;
   } issue_type;

   typedef struct packed {
      logic      wr_en;
      addr_type  wr_addr;
      entry_type wr_data;
      logic      rd_en;
      addr_type  rd_addr;
   } mem_req_type;

   function automatic coord_type wrap_coord(input logic [IN_COORD_W-1:0] v);
      logic [IN_COORD_W-1:0] r;
      r = v;
      for (int i = 0; i < WRAP_STEPS; i++) begin
         if (int'(r) >= GRID_SIZE) begin
            r = r - IN_COORD_W'(GRID_SIZE);
         end
      end
      return COORD_W'(r);
   endfunction

   function automatic coord_type coord_inc(input coord_type c);
      return (int'(c) == GRID_SIZE - 1) ? '0 : c + COORD_W'(1);
   endfunction

   function automatic coord_type coord_dec(input coord_type c);
      return (c == '0) ? COORD_W'(GRID_SIZE - 1) : c - COORD_W'(1);
   endfunction

   function automatic addr_type cell_addr(input coord_type x, input coord_type y);
      return ADDR_W'(x) * ADDR_W'(GRID_SIZE) + ADDR_W'(y);
   endfunction

   function automatic entry_type cell_reset_value(input addr_type a);
      entry_type v;
      v = '0;
      if (a == cell_addr(COORD_W'(0), COORD_W'(0))) begin
         v = {ORIGIN_WALLS, VALUE_W'(0)};
      end else if (a == cell_addr(COORD_W'(CENTRE), COORD_W'(CENTRE)) ||
                   a == cell_addr(COORD_W'(CENTRE - 1), COORD_W'(CENTRE)) ||
                   a == cell_addr(COORD_W'(CENTRE - 1), COORD_W'(CENTRE - 1)) ||
                   a == cell_addr(COORD_W'(CENTRE), COORD_W'(CENTRE - 1))) begin
         v = {WALL_W'(0), CENTRE_VALUE};
      end
      return v;
   endfunction

endpackage

// ===== design/gmpt_cell_store.sv =====
// Cell memory of the grid map: one write port and one read port with
// registered read data. Depends on gmpt_pkg.
`timescale 1ns / 1ps

module gmpt_cell_store (
   input  logic                  clock,
   input  gmpt_pkg::mem_req_type mem_req,
   output gmpt_pkg::entry_type   rd_data
);
   import gmpt_pkg::*;

   entry_type cell_mem [CELL_COUNT];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         cell_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // Read data holds between reads, so a stalled command keeps its entry.
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= cell_mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/gmpt_pose_unit.sv =====
// Robot pose registers and command decode: next pose, the cell address each
// command reads and the absolute wall it marks. Depends on gmpt_pkg.
`timescale 1ns / 1ps

module gmpt_pose_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            issue,
   input  logic [gmpt_pkg::CMD_W-1:0]      cmd,
   input  logic [gmpt_pkg::IN_COORD_W-1:0] cell_x,
   input  logic [gmpt_pkg::IN_COORD_W-1:0] cell_y,
   input  logic [gmpt_pkg::DIR_W-1:0]      direction_code,
   output gmpt_pkg::pose_type              pose,
   output gmpt_pkg::addr_type              here_addr,
   output gmpt_pkg::issue_type             issue_info
);
   import gmpt_pkg::*;

   pose_type         pose_ff;
   pose_type         pose_in;
   pose_type         moved_pose;
   coord_type        abs_x;
   coord_type        abs_y;
   logic [DIR_W-1:0] rel_card;

   assign abs_x = wrap_coord(cell_x);
   assign abs_y = wrap_coord(cell_y);

   always_comb begin
      moved_pose = pose_ff;
      case (pose_ff.heading)
         HEAD_N:  moved_pose.y = coord_inc(pose_ff.y);
         HEAD_E:  moved_pose.x = coord_inc(pose_ff.x);
         HEAD_S:  moved_pose.y = coord_dec(pose_ff.y);
         HEAD_W:  moved_pose.x = coord_dec(pose_ff.x);
         default: moved_pose = pose_ff;
      endcase
   end

   always_comb begin
      case (direction_code)
         REL_LEFT:  rel_card = pose_ff.heading - DIR_W'(1);
         REL_RIGHT: rel_card = pose_ff.heading + DIR_W'(1);
         default:   rel_card = pose_ff.heading;
      endcase
   end

   always_comb begin
      pose_in         = pose_ff;
      issue_info.addr = cell_addr(pose_ff.x, pose_ff.y);
      issue_info.card = rel_card;
      case (cmd)
         CMD_LEFT: begin
            pose_in.heading = pose_ff.heading - DIR_W'(1);
         end
         CMD_RIGHT: begin
            pose_in.heading = pose_ff.heading + DIR_W'(1);
         end
         CMD_FORWARD: begin
            pose_in         = moved_pose;
            issue_info.addr = cell_addr(moved_pose.x, moved_pose.y);
         end
         CMD_WALL_ABS: begin
            issue_info.addr = cell_addr(abs_x, abs_y);
            issue_info.card = direction_code;
         end
         CMD_SET, CMD_READ: begin
            issue_info.addr = cell_addr(abs_x, abs_y);
         end
         default: begin
            pose_in = pose_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pose_ff <= '{x: '0, y: '0, heading: HEAD_N};
      end else if (issue) begin
         pose_ff <= pose_in;
      end
   end

   assign pose      = pose_ff;
   assign here_addr = cell_addr(pose_ff.x, pose_ff.y);

endmodule

// ===== design/grid_map_pose_tracker.sv =====
// Grid map pose tracker: command sequencer, read-modify-write of the cell
// memory and the result register. Depends on gmpt_pkg, gmpt_pose_unit, gmpt_cell_store.
`timescale 1ns / 1ps
//
// Usage
// The req_ channel takes one command word (turn, forward, wall mark, set value or
// read cell); the rsp_ channel returns exactly one word per command: the pose after
// the command and the value and walls of the addressed cell, or of the robot's cell
// for commands that address none. Cell contents are shown after the update.
// On acceptance the memory read is issued; the modify state then waits until the
// result register is free, modifies the entry, writes it back and loads the result.
// With a single memory port pair, no new command is taken until the last one has
// left the modify state. Commands never overlap, so a read never meets a pending
// write to the same cell.
// The robot's own step value is also held in a register, so forward needs one read.
// After reset the memory is swept, one cell per cycle, to its initial map; req_ready
// stays low until all CELL_COUNT cells (256 for a 16 by 16 grid) are written.
// The pose resets to the origin facing north.
// A result waits in its register while rsp_ready is low; the next command may be
// accepted meanwhile, and its write-back waits until the register is free.
//
module grid_map_pose_tracker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [gmpt_pkg::CMD_W-1:0]      req_cmd,
   input  logic [gmpt_pkg::IN_COORD_W-1:0] req_cell_x,
   input  logic [gmpt_pkg::IN_COORD_W-1:0] req_cell_y,
   input  logic [gmpt_pkg::DIR_W-1:0]      req_direction_code,
   input  logic [gmpt_pkg::VALUE_W-1:0]    req_step_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [gmpt_pkg::IN_COORD_W-1:0] rsp_pos_x,
   output logic [gmpt_pkg::IN_COORD_W-1:0] rsp_pos_y,
   output logic [gmpt_pkg::DIR_W-1:0]      rsp_heading,
   output logic [gmpt_pkg::VALUE_W-1:0]    rsp_cell_value,
   output logic [gmpt_pkg::WALL_W-1:0]     rsp_cell_walls
);
   import gmpt_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_MODIFY = 3'b100
   } state_type;

   state_type           state_ff;
   state_type           state_in;
   addr_type            clear_addr_ff;
   logic [CMD_W-1:0]    cmd_ff;
   addr_type            addr_ff;
   logic [DIR_W-1:0]    card_ff;
   logic [VALUE_W-1:0]  sval_ff;
   logic [VALUE_W-1:0]  here_value_ff;
   logic                rsp_valid_ff;
   logic [IN_COORD_W-1:0] pos_x_ff;
   logic [IN_COORD_W-1:0] pos_y_ff;
   logic [DIR_W-1:0]    heading_ff;
   entry_type           rsp_cell_ff;

   logic                accept;
   logic                slot_free;
   logic                finish;
   logic                do_write;
   entry_type           rd_data;
   entry_type           new_entry;
   entry_type           wall_bit;
   pose_type            pose;
   addr_type            here_addr;
   issue_type           issue_info;
   mem_req_type         mem_req;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign finish    = (state_ff == ST_MODIFY) && slot_free;

   gmpt_pose_unit u_pose (
      .clock          (clock),
      .reset          (reset),
      .issue          (accept),
      .cmd            (req_cmd),
      .cell_x         (req_cell_x),
      .cell_y         (req_cell_y),
      .direction_code (req_direction_code),
      .pose           (pose),
      .here_addr      (here_addr),
      .issue_info     (issue_info)
   );

   gmpt_cell_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign wall_bit = entry_type'(1) << (VALUE_W + int'(card_ff));

   always_comb begin
      new_entry = rd_data;
      do_write  = 1'b0;
      case (cmd_ff)
         CMD_FORWARD: begin
            new_entry = {rd_data[ENTRY_W-1:VALUE_W], here_value_ff + VALUE_W'(1)};
            do_write  = 1'b1;
         end
         CMD_WALL_REL, CMD_WALL_ABS: begin
            new_entry = rd_data | wall_bit;
            do_write  = 1'b1;
         end
         CMD_SET: begin
            new_entry = {rd_data[ENTRY_W-1:VALUE_W], sval_ff};
            do_write  = 1'b1;
         end
         default: begin
            new_entry = rd_data;
         end
      endcase
   end

   always_comb begin
      mem_req.rd_en   = accept;
      mem_req.rd_addr = issue_info.addr;
      if (state_ff == ST_CLEAR) begin
         mem_req.wr_en   = 1'b1;
         mem_req.wr_addr = clear_addr_ff;
         mem_req.wr_data = cell_reset_value(clear_addr_ff);
      end else begin
         mem_req.wr_en   = finish && do_write;
         mem_req.wr_addr = addr_ff;
         mem_req.wr_data = new_entry;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_addr_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MODIFY;
            end
         end
         ST_MODIFY: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         here_value_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clear_addr_ff <= clear_addr_ff + ADDR_W'(1);
         end
         // The robot's step value follows every write that lands on its cell.
         if (finish && cmd_ff == CMD_FORWARD) begin
            here_value_ff <= here_value_ff + VALUE_W'(1);
         end else if (finish && cmd_ff == CMD_SET && addr_ff == here_addr) begin
            here_value_ff <= sval_ff;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_cmd;
         addr_ff <= issue_info.addr;
         card_ff <= issue_info.card;
         sval_ff <= req_step_value;
      end
      if (finish) begin
         pos_x_ff    <= IN_COORD_W'(pose.x);
         pos_y_ff    <= IN_COORD_W'(pose.y);
         heading_ff  <= pose.heading;
         rsp_cell_ff <= new_entry;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pos_x      = pos_x_ff;
   assign rsp_pos_y      = pos_y_ff;
   assign rsp_heading    = heading_ff;
   assign rsp_cell_value = rsp_cell_ff[VALUE_W-1:0];
   assign rsp_cell_walls = rsp_cell_ff[ENTRY_W-1:VALUE_W];

endmodule

// ===== design/gmpt_checker.sv =====
// Port-level checks for the grid map pose tracker, bound to its top level.
// Depends on gmpt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gmpt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [gmpt_pkg::IN_COORD_W-1:0] rsp_pos_x,
   input logic [gmpt_pkg::IN_COORD_W-1:0] rsp_pos_y,
   input logic [gmpt_pkg::DIR_W-1:0]      rsp_heading,
   input logic [gmpt_pkg::VALUE_W-1:0]    rsp_cell_value,
   input logic [gmpt_pkg::WALL_W-1:0]     rsp_cell_walls
);
   import gmpt_pkg::*;

   // Reset starts the memory sweep, so no word is offered or taken just after it.
   `GMPT_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> (!rsp_valid && !req_ready), "busy after reset")

   // A command holds the sequencer while it is in the modify state.
   `GMPT_ASSERT(a_two_cycle, clock, reset, (req_valid && req_ready) |=> !req_ready, "back-to-back accept")

   `GMPT_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid, "result word dropped")

   `GMPT_ASSERT(a_rsp_stable, clock, reset, (rsp_valid && !rsp_ready) |=> ($stable(rsp_pos_x) && $stable(rsp_pos_y) && $stable(rsp_heading) && $stable(rsp_cell_value) && $stable(rsp_cell_walls)), "stalled result word changed")

endmodule

bind grid_map_pose_tracker gmpt_checker u_gmpt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_pos_x      (rsp_pos_x),
   .rsp_pos_y      (rsp_pos_y),
   .rsp_heading    (rsp_heading),
   .rsp_cell_value (rsp_cell_value),
   .rsp_cell_walls (rsp_cell_walls)
);
